// ----- hw/rtl/fractional_pid_sample_step_unit_defines.svh -----
// Assertion macros for the RTL files; fpss_ctrl.sv includes them.
`ifndef FRACTIONAL_PID_SAMPLE_STEP_UNIT_DEFINES_SVH
`define FRACTIONAL_PID_SAMPLE_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPSS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FPSS_NEVER(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define FPSS_ASSERT(name, clk, rstn, prop, msg)
`define FPSS_NEVER(name, clk, rstn, prop, msg)
`endif
`endif

// ----- hw/rtl/fpss_pkg.sv -----
package fpss_pkg;

    localparam int MAX_SECTIONS_DEF  = 11;
    localparam int FRACTION_BITS_DEF = 28;

    localparam int DATA_W      = 48;
    localparam int ACC_W       = 50;
    localparam int EXT_W       = ACC_W - DATA_W;
    localparam int COEF_W      = 32;
    localparam int SEC_IDX_W   = 4;
    localparam int OUT_W       = 30;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_MARGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IFILT_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DFILT_GAIN  = 3'd7;

    localparam logic [31:0] RST_PROP_GAIN   = 32'd268435456;
    localparam logic [31:0] RST_INTEG_GAIN  = 32'd0;
    localparam logic [31:0] RST_DERIV_GAIN  = 32'd0;
    localparam logic [30:0] RST_STEP_TIME   = 31'd2684355;
    localparam logic [30:0] RST_JUMP_MARGIN = 31'd161061274;
    localparam logic [3:0]  RST_SECTIONS    = 4'd6;
    localparam logic [31:0] RST_IFILT_GAIN  = 32'd268435456;
    localparam logic [31:0] RST_DFILT_GAIN  = 32'd268435456;

    localparam logic [1:0] COEF_B1 = 2'd0;
    localparam logic [1:0] COEF_B2 = 2'd1;
    localparam logic [1:0] COEF_A1 = 2'd2;
    localparam logic [1:0] COEF_A2 = 2'd3;

    localparam logic WORD_S0 = 1'b0;
    localparam logic WORD_S1 = 1'b1;

    typedef enum logic [1:0] {ASEL_X, ASEL_U, ASEL_Y, ASEL_T} asel_t;
    typedef enum logic [2:0] {
        CSEL_COEF, CSEL_FGAIN, CSEL_KI, CSEL_KD, CSEL_TS, CSEL_KP
    } csel_t;
    typedef enum logic [2:0] {
        DST_U, DST_T, DST_INTEG, DST_ACC_SET, DST_ACC_S1ADD, DST_ACC_ADD, DST_ACC_SUB
    } dst_t;

    typedef struct packed {
        logic                 take_sample;
        logic                 load_coef;
        logic                 mul_start;
        asel_t                a_sel;
        csel_t                c_sel;
        dst_t                 dst;
        logic                 rd_issue;
        logic [1:0]           cidx;
        logic                 rd_cap;
        logic [1:0]           cap_idx;
        logic                 y_load;
        logic                 mem_we;
        logic                 mem_word;
        logic                 u_from_y;
        logic                 acc_add_integ;
        logic                 out_load;
        logic                 sel;
        logic [SEC_IDX_W-1:0] sec;
    } cmd_t;

    typedef struct packed {
        logic                 mul_done;
        logic                 sample_item;
        logic                 out_free;
        logic [SEC_IDX_W-1:0] sec_last;
    } sts_t;

    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic [EXT_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- hw/rtl/fpss_ram.sv -----
module fpss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/fpss_mul.sv -----
module fpss_mul #(
    parameter int FRACTION_BITS = 28
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [fpss_pkg::DATA_W-1:0] a,
    input  logic signed [fpss_pkg::COEF_W-1:0] c,
    output logic                              done,
    output logic signed [fpss_pkg::DATA_W-1:0] p
);
    import fpss_pkg::*;

    localparam int FULL_W = DATA_W + COEF_W;

    logic [4:0]               v_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [COEF_W-1:0] c_reg;
    logic signed [48:0]       plo_reg;
    logic signed [63:0]       phi_reg;
    logic signed [FULL_W-1:0] full_reg;
    logic signed [DATA_W-1:0] p_reg;
    logic signed [FULL_W-1:0] shifted;
    logic [FULL_W-DATA_W:0]   top;

    assign shifted = full_reg >>> FRACTION_BITS;
    assign top     = shifted[FULL_W-1:DATA_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[3:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            c_reg <= c;
        end
        if (v_reg[0]) begin
            plo_reg <= $signed({1'b0, a_reg[15:0]}) * c_reg;
        end
        if (v_reg[1]) begin
            phi_reg <= $signed(a_reg[DATA_W-1:16]) * c_reg;
        end
        if (v_reg[2]) begin
            full_reg <= $signed({phi_reg, 16'h0000}) + $signed({{31{plo_reg[48]}}, plo_reg});
        end
        if (v_reg[3]) begin
            if (top == '0 || top == '1) begin
                p_reg <= shifted[DATA_W-1:0];
            end else if (shifted[FULL_W-1]) begin
                p_reg <= {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                p_reg <= {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    assign done = v_reg[4];
    assign p    = p_reg;

endmodule

// ----- hw/rtl/fpss_datapath.sv -----
module fpss_datapath #(
    parameter int MAX_SECTIONS  = 11,
    parameter int FRACTION_BITS = 28
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [fpss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpss_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic [fpss_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tuser,
    input  fpss_pkg::cmd_t                        cmd,
    output fpss_pkg::sts_t                        sts,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fpss_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import fpss_pkg::*;

    localparam int CDEPTH = 2 * MAX_SECTIONS * 4;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int SDEPTH = 2 * MAX_SECTIONS * 2;
    localparam int SA_W   = $clog2(SDEPTH);
    localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [ACC_W-1:0] NEG_ONE_Q = -ONE_Q;

    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [31:0] ifilt_gain_reg, dfilt_gain_reg;
    logic [30:0]        step_time_reg, jump_margin_reg;
    logic [3:0]         sections_reg;

    logic                 in_fsel;
    logic [SEC_IDX_W-1:0] in_sec;
    logic [1:0]           in_ci;
    logic [31:0]          in_coef;
    logic signed [31:0]   in_x;

    logic signed [31:0]       x_reg, prev_reg;
    logic signed [DATA_W-1:0] u_reg, y_reg, t_reg, integ_reg;
    logic signed [DATA_W-1:0] s_reg [2];
    logic signed [31:0]       coef_reg [4];
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     cleared_reg, sval_rd_reg;
    logic [SDEPTH-1:0]        svalid_reg;
    dst_t                     dst_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic signed [32:0]       diff, adiff;
    logic                     jump;
    logic [4:0]               eff_cnt;
    logic                     c_we;
    logic [CA_W-1:0]          c_waddr, c_raddr;
    logic [31:0]              c_rdata;
    logic [SA_W-1:0]          s_addr_rd, s_addr_wr;
    logic [DATA_W-1:0]        s_rdata;
    logic signed [DATA_W-1:0] mul_a, mul_p;
    logic signed [COEF_W-1:0] mul_c;
    logic                     mul_done;
    logic signed [ACC_W-1:0]  p_ext, acc_sat_in;
    logic signed [DATA_W-1:0] acc_sat;
    logic signed [ACC_W-1:0]  clamped;
    logic                     clip;

    assign in_fsel = s_tdata[0];
    assign in_sec  = s_tdata[4:1];
    assign in_ci   = s_tdata[6:5];
    assign in_coef = s_tdata[38:7];
    assign in_x    = s_tdata[70:39];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= RST_PROP_GAIN;
            integ_gain_reg  <= RST_INTEG_GAIN;
            deriv_gain_reg  <= RST_DERIV_GAIN;
            step_time_reg   <= RST_STEP_TIME;
            jump_margin_reg <= RST_JUMP_MARGIN;
            sections_reg    <= RST_SECTIONS;
            ifilt_gain_reg  <= RST_IFILT_GAIN;
            dfilt_gain_reg  <= RST_DFILT_GAIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata;
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata;
                CFG_STEP_TIME:   step_time_reg   <= cfg_wdata[30:0];
                CFG_JUMP_MARGIN: jump_margin_reg <= cfg_wdata[30:0];
                CFG_SECTIONS:    sections_reg    <= cfg_wdata[3:0];
                CFG_IFILT_GAIN:  ifilt_gain_reg  <= cfg_wdata;
                CFG_DFILT_GAIN:  dfilt_gain_reg  <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        if (sections_reg == 4'd0) begin
            eff_cnt = 5'd1;
        end else if (5'(sections_reg) > 5'(MAX_SECTIONS)) begin
            eff_cnt = 5'(MAX_SECTIONS);
        end else begin
            eff_cnt = 5'(sections_reg);
        end
    end

    assign diff  = $signed({in_x[31], in_x}) - $signed({prev_reg[31], prev_reg});
    assign adiff = diff[32] ? -diff : diff;
    assign jump  = adiff > $signed({2'b00, jump_margin_reg});

    // coefficient store
    assign c_we    = cmd.load_coef && (32'(in_sec) < 32'(MAX_SECTIONS));
    assign c_waddr = CA_W'((int'(in_fsel) * MAX_SECTIONS + int'(in_sec)) * 4 + int'(in_ci));
    assign c_raddr = CA_W'((int'(cmd.sel) * MAX_SECTIONS + int'(cmd.sec)) * 4 + int'(cmd.cidx));

    fpss_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (in_coef),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // section state store
    assign s_addr_rd = SA_W'((int'(cmd.sel) * MAX_SECTIONS + int'(cmd.sec)) * 2
                             + int'(cmd.cidx[0]));
    assign s_addr_wr = SA_W'((int'(cmd.sel) * MAX_SECTIONS + int'(cmd.sec)) * 2
                             + int'(cmd.mem_word));

    fpss_ram #(.WIDTH(DATA_W), .DEPTH(SDEPTH)) u_state_ram (
        .aclk  (aclk),
        .we    (cmd.mem_we),
        .waddr (s_addr_wr),
        .wdata (acc_sat),
        .raddr (s_addr_rd),
        .rdata (s_rdata)
    );

    always_comb begin
        unique case (cmd.a_sel)
            ASEL_X:  mul_a = DATA_W'(x_reg);
            ASEL_U:  mul_a = u_reg;
            ASEL_Y:  mul_a = y_reg;
            ASEL_T:  mul_a = t_reg;
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.c_sel)
            CSEL_COEF:  mul_c = coef_reg[cmd.cidx];
            CSEL_FGAIN: mul_c = cmd.sel ? dfilt_gain_reg : ifilt_gain_reg;
            CSEL_KI:    mul_c = integ_gain_reg;
            CSEL_KD:    mul_c = deriv_gain_reg;
            CSEL_TS:    mul_c = $signed({1'b0, step_time_reg});
            CSEL_KP:    mul_c = prop_gain_reg;
            default:    mul_c = '0;
        endcase
    end

    fpss_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .c       (mul_c),
        .done    (mul_done),
        .p       (mul_p)
    );

    assign p_ext      = {{EXT_W{mul_p[DATA_W-1]}}, mul_p};
    assign acc_sat_in = acc_reg;
    assign acc_sat    = sat48(acc_sat_in);

    always_comb begin
        clip    = 1'b0;
        clamped = acc_reg;
        if (acc_reg > ONE_Q) begin
            clamped = ONE_Q;
            clip    = 1'b1;
        end else if (acc_reg < NEG_ONE_Q) begin
            clamped = NEG_ONE_Q;
            clip    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            integ_reg    <= '0;
            svalid_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.take_sample) begin
                prev_reg <= in_x;
                if (jump) begin
                    integ_reg  <= '0;
                    svalid_reg <= '0;
                end
            end
            if (cmd.mem_we) begin
                svalid_reg[s_addr_wr] <= 1'b1;
            end
            if (mul_done && dst_reg == DST_INTEG) begin
                integ_reg <= sat48({{EXT_W{integ_reg[DATA_W-1]}}, integ_reg} + p_ext);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_sample) begin
            x_reg       <= in_x;
            cleared_reg <= jump;
        end
        if (cmd.mul_start) begin
            dst_reg <= cmd.dst;
        end
        if (cmd.rd_issue) begin
            sval_rd_reg <= svalid_reg[s_addr_rd];
        end
        if (cmd.rd_cap) begin
            coef_reg[cmd.cap_idx] <= c_rdata;
            if (!cmd.cap_idx[1]) begin
                s_reg[cmd.cap_idx[0]] <= sval_rd_reg ? s_rdata : '0;
            end
        end
        if (cmd.y_load) begin
            y_reg <= sat48({{EXT_W{u_reg[DATA_W-1]}}, u_reg}
                           + {{EXT_W{s_reg[0][DATA_W-1]}}, s_reg[0]});
        end
        if (cmd.u_from_y) begin
            u_reg <= y_reg;
        end
        if (cmd.acc_add_integ) begin
            acc_reg <= acc_reg + {{EXT_W{integ_reg[DATA_W-1]}}, integ_reg};
        end
        if (mul_done) begin
            unique case (dst_reg)
                DST_U:         u_reg   <= mul_p;
                DST_T:         t_reg   <= mul_p;
                DST_ACC_SET:   acc_reg <= p_ext;
                DST_ACC_S1ADD: acc_reg <= {{EXT_W{s_reg[1][DATA_W-1]}}, s_reg[1]} + p_ext;
                DST_ACC_ADD:   acc_reg <= acc_reg + p_ext;
                DST_ACC_SUB:   acc_reg <= acc_reg - p_ext;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {cleared_reg, clip, clamped[OUT_W-1:0]};
        end
    end

    assign sts.mul_done    = mul_done;
    assign sts.sample_item = s_tuser;
    assign sts.out_free    = !m_tvalid_reg || m_tready;
    assign sts.sec_last    = SEC_IDX_W'(eff_cnt - 5'd1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/fpss_ctrl.sv -----
`include "fractional_pid_sample_step_unit_defines.svh"

module fpss_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  fpss_pkg::sts_t sts,
    output fpss_pkg::cmd_t cmd
);
    import fpss_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_GAIN = 16'h0002,
        ST_READ = 16'h0004,
        ST_YSUM = 16'h0008,
        ST_UB1  = 16'h0010,
        ST_YA1  = 16'h0020,
        ST_WS0  = 16'h0040,
        ST_UB2  = 16'h0080,
        ST_YA2  = 16'h0100,
        ST_WS1  = 16'h0200,
        ST_KI   = 16'h0400,
        ST_KD   = 16'h0800,
        ST_TS   = 16'h1000,
        ST_KP   = 16'h2000,
        ST_SUM  = 16'h4000,
        ST_OUT  = 16'h8000
    } state_t;

    state_t               state_reg, state_next;
    logic                 busy_reg, busy_next;
    logic [2:0]           rd_cnt_reg, rd_cnt_next;
    logic                 sel_reg, sel_next;
    logic [SEC_IDX_W-1:0] sec_reg, sec_next;
    logic                 is_mul, mul_fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            rd_cnt_reg <= '0;
            sel_reg    <= 1'b0;
            sec_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            rd_cnt_reg <= rd_cnt_next;
            sel_reg    <= sel_next;
            sec_reg    <= sec_next;
        end
    end

    assign is_mul = (state_reg == ST_GAIN) || (state_reg == ST_UB1) || (state_reg == ST_YA1)
                 || (state_reg == ST_UB2) || (state_reg == ST_YA2) || (state_reg == ST_KI)
                 || (state_reg == ST_KD) || (state_reg == ST_TS) || (state_reg == ST_KP);
    assign mul_fin = busy_reg && sts.mul_done;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        rd_cnt_next = rd_cnt_reg;
        sel_next    = sel_reg;
        sec_next    = sec_reg;
        cmd         = '0;
        cmd.a_sel   = ASEL_U;
        cmd.c_sel   = CSEL_COEF;
        cmd.dst     = DST_U;
        cmd.sel     = sel_reg;
        cmd.sec     = sec_reg;

        if (is_mul) begin
            cmd.mul_start = !busy_reg;
            busy_next     = busy_reg ? !sts.mul_done : 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (sts.sample_item) begin
                        cmd.take_sample = 1'b1;
                        sel_next        = 1'b0;
                        sec_next        = '0;
                        state_next      = ST_GAIN;
                    end else begin
                        cmd.load_coef = 1'b1;
                    end
                end
            end
            ST_GAIN: begin
                cmd.a_sel = ASEL_X;
                cmd.c_sel = CSEL_FGAIN;
                cmd.dst   = DST_U;
                if (mul_fin) begin
                    rd_cnt_next = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = !rd_cnt_reg[2];
                cmd.cidx     = rd_cnt_reg[1:0];
                cmd.rd_cap   = (rd_cnt_reg != 3'd0);
                cmd.cap_idx  = 2'(rd_cnt_reg - 3'd1);
                rd_cnt_next  = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg[2]) begin
                    state_next = ST_YSUM;
                end
            end
            ST_YSUM: begin
                cmd.y_load = 1'b1;
                state_next = ST_UB1;
            end
            ST_UB1: begin
                cmd.a_sel = ASEL_U;
                cmd.cidx  = COEF_B1;
                cmd.dst   = DST_ACC_S1ADD;
                if (mul_fin) begin
                    state_next = ST_YA1;
                end
            end
            ST_YA1: begin
                cmd.a_sel = ASEL_Y;
                cmd.cidx  = COEF_A1;
                cmd.dst   = DST_ACC_SUB;
                if (mul_fin) begin
                    state_next = ST_WS0;
                end
            end
            ST_WS0: begin
                cmd.mem_we   = 1'b1;
                cmd.mem_word = WORD_S0;
                state_next   = ST_UB2;
            end
            ST_UB2: begin
                cmd.a_sel = ASEL_U;
                cmd.cidx  = COEF_B2;
                cmd.dst   = DST_ACC_SET;
                if (mul_fin) begin
                    state_next = ST_YA2;
                end
            end
            ST_YA2: begin
                cmd.a_sel = ASEL_Y;
                cmd.cidx  = COEF_A2;
                cmd.dst   = DST_ACC_SUB;
                if (mul_fin) begin
                    state_next = ST_WS1;
                end
            end
            ST_WS1: begin
                cmd.mem_we   = 1'b1;
                cmd.mem_word = WORD_S1;
                cmd.u_from_y = 1'b1;
                if (sec_reg == sts.sec_last) begin
                    state_next = sel_reg ? ST_KD : ST_KI;
                end else begin
                    sec_next    = sec_reg + 1'b1;
                    rd_cnt_next = '0;
                    state_next  = ST_READ;
                end
            end
            ST_KI: begin
                cmd.a_sel = ASEL_U;
                cmd.c_sel = CSEL_KI;
                cmd.dst   = DST_T;
                if (mul_fin) begin
                    sel_next   = 1'b1;
                    sec_next   = '0;
                    state_next = ST_GAIN;
                end
            end
            ST_KD: begin
                cmd.a_sel = ASEL_U;
                cmd.c_sel = CSEL_KD;
                cmd.dst   = DST_ACC_SET;
                if (mul_fin) begin
                    state_next = ST_TS;
                end
            end
            ST_TS: begin
                cmd.a_sel = ASEL_T;
                cmd.c_sel = CSEL_TS;
                cmd.dst   = DST_INTEG;
                if (mul_fin) begin
                    state_next = ST_KP;
                end
            end
            ST_KP: begin
                cmd.a_sel = ASEL_X;
                cmd.c_sel = CSEL_KP;
                cmd.dst   = DST_ACC_ADD;
                if (mul_fin) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.acc_add_integ = 1'b1;
                state_next        = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `FPSS_ASSERT(a_done_busy, aclk, aresetn, sts.mul_done |-> busy_reg, "product without request")
    `FPSS_ASSERT(a_out_free, aclk, aresetn, cmd.out_load |-> sts.out_free, "result overwritten")
    `FPSS_ASSERT(a_ready_quiet, aclk, aresetn, s_tready |-> !busy_reg, "ready with product due")
    `FPSS_NEVER(a_start_twice, aclk, aresetn, cmd.mul_start && busy_reg, "second product request")

endmodule

// ----- hw/rtl/fractional_pid_sample_step_unit.sv -----
// Fractional-order PID step unit, Q3.28 by default. An item with s_tuser 0 loads one biquad
// coefficient (no result); an item with s_tuser 1 runs one error sample through the
// integrator and differentiator biquad cascades and yields one clamped control result.
// Every product of a sample goes through one shared multiplier that splits the 48x32 product
// into two partial products, four products per section. Section state sits in a RAM tracked by
// valid bits, so reset and the jump rule clear it at once; there is no clearing pass.
module fractional_pid_sample_step_unit #(
    parameter int MAX_SECTIONS  = fpss_pkg::MAX_SECTIONS_DEF,
    parameter int FRACTION_BITS = fpss_pkg::FRACTION_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fpss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpss_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // filter_select, section_index[3:0], coef_index[1:0], coef_value[31:0],
    // error_sample[31:0], zero pad
    input  logic [fpss_pkg::IN_TDATA_W-1:0]    s_tdata,
    // mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // control_out[29:0], was_clamped, memory_cleared
    output logic [fpss_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import fpss_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fpss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpss_datapath #(
        .MAX_SECTIONS  (MAX_SECTIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- verif/fpss_tb_pkg.sv -----
`timescale 1ns / 1ps

package fpss_tb_pkg;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic SEL_INTEG = 1'b0;
    localparam logic SEL_DIFF  = 1'b1;

    localparam int TB_MAX_SECTIONS = 11;
    localparam int TB_FRAC_BITS    = 28;

endpackage

// ----- verif/fractional_pid_sample_step_checker.sv -----
`timescale 1ns / 1ps

module fractional_pid_sample_step_checker
    import fpss_pkg::*;
    import fpss_tb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);

    localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -S48_MAX - 1;
    localparam longint ONE_Q   = 64'sd1 << TB_FRAC_BITS;

    typedef struct packed {
        logic             memory_cleared;
        logic             was_clamped;
        logic [OUT_W-1:0] control_out;
    } control_result_t;

    control_result_t expected_controls[$];

    logic [COEF_W-1:0] coef_table [2][TB_MAX_SECTIONS][4];
    longint            biquad_state [2][TB_MAX_SECTIONS][2];
    longint            integ_acc;
    longint            last_error;

    longint kp, ki, kd, ts, margin, ifg, dfg;
    logic [3:0] section_count;

    function automatic longint sat48(input longint v);
        if (v > S48_MAX) return S48_MAX;
        if (v < S48_MIN) return S48_MIN;
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint c);
        logic signed [95:0] pa, pc, prod;
        pa = a;
        pc = c;
        prod = (pa * pc) >>> TB_FRAC_BITS;
        if (prod > S48_MAX) return S48_MAX;
        if (prod < S48_MIN) return S48_MIN;
        return longint'(prod);
    endfunction

    function automatic longint cascade_out(input int sel, input longint gain,
                                           input longint x, input int count);
        longint u, y, b1, b2, a1, a2;
        u = fix_mul(x, gain);
        for (int m = 0; m < count; m++) begin
            b1 = longint'($signed(coef_table[sel][m][COEF_B1]));
            b2 = longint'($signed(coef_table[sel][m][COEF_B2]));
            a1 = longint'($signed(coef_table[sel][m][COEF_A1]));
            a2 = longint'($signed(coef_table[sel][m][COEF_A2]));
            y = sat48(u + biquad_state[sel][m][0]);
            biquad_state[sel][m][0] = sat48(fix_mul(u, b1) - fix_mul(y, a1)
                                            + biquad_state[sel][m][1]);
            biquad_state[sel][m][1] = sat48(fix_mul(u, b2) - fix_mul(y, a2));
            u = y;
        end
        return u;
    endfunction

    function automatic control_result_t control_step(input logic [31:0] err);
        control_result_t r;
        longint x, diff, fi, fd, total, clamped;
        int count;
        x = longint'($signed(err));
        diff = x - last_error;
        if (diff < 0) diff = -diff;
        r.memory_cleared = 1'b0;
        if (diff > margin) begin
            foreach (biquad_state[i, j, k]) biquad_state[i][j][k] = 0;
            integ_acc = 0;
            r.memory_cleared = 1'b1;
        end
        last_error = x;
        count = section_count;
        if (count < 1) count = 1;
        if (count > TB_MAX_SECTIONS) count = TB_MAX_SECTIONS;
        fi = fix_mul(cascade_out(0, ifg, x, count), ki);
        fd = fix_mul(cascade_out(1, dfg, x, count), kd);
        integ_acc = sat48(integ_acc + fix_mul(fi, ts));
        total = fix_mul(x, kp) + integ_acc + fd;
        clamped = total;
        r.was_clamped = 1'b0;
        if (total > ONE_Q) begin
            clamped = ONE_Q;
            r.was_clamped = 1'b1;
        end
        if (total < -ONE_Q) begin
            clamped = -ONE_Q;
            r.was_clamped = 1'b1;
        end
        r.control_out = clamped[OUT_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_controls.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        control_result_t got, want;
        if (!aresetn) begin
            foreach (biquad_state[i, j, k]) biquad_state[i][j][k] = 0;
            foreach (coef_table[i, j, k]) coef_table[i][j][k] = '0;
            integ_acc = 0;
            last_error = 0;
            kp = longint'($signed(RST_PROP_GAIN));
            ki = longint'($signed(RST_INTEG_GAIN));
            kd = longint'($signed(RST_DERIV_GAIN));
            ts = longint'(RST_STEP_TIME);
            margin = longint'(RST_JUMP_MARGIN);
            section_count = RST_SECTIONS;
            ifg = longint'($signed(RST_IFILT_GAIN));
            dfg = longint'($signed(RST_DFILT_GAIN));
            expected_controls.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PROP_GAIN:   kp = longint'($signed(cfg_wdata));
                    CFG_INTEG_GAIN:  ki = longint'($signed(cfg_wdata));
                    CFG_DERIV_GAIN:  kd = longint'($signed(cfg_wdata));
                    CFG_STEP_TIME:   ts = longint'(cfg_wdata[30:0]);
                    CFG_JUMP_MARGIN: margin = longint'(cfg_wdata[30:0]);
                    CFG_SECTIONS:    section_count = cfg_wdata[3:0];
                    CFG_IFILT_GAIN:  ifg = longint'($signed(cfg_wdata));
                    CFG_DFILT_GAIN:  dfg = longint'($signed(cfg_wdata));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_LOAD) begin
                    if (s_tdata[4:1] < TB_MAX_SECTIONS)
                        coef_table[s_tdata[0]][s_tdata[4:1]][s_tdata[6:5]] = s_tdata[38:7];
                end else begin
                    expected_controls.push_back(control_step(s_tdata[70:39]));
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_controls.size() == 0) begin
                    report("unexpected item", m_tdata, '0);
                end else begin
                    want = expected_controls.pop_front();
                    if (got.control_out !== want.control_out)
                        report("control_out", got.control_out, want.control_out);
                    if (got.was_clamped !== want.was_clamped)
                        report("was_clamped", got.was_clamped, want.was_clamped);
                    if (got.memory_cleared !== want.memory_cleared)
                        report("memory_cleared", got.memory_cleared, want.memory_cleared);
                end
            end
        end
    end

endmodule

// ----- verif/fractional_pid_sample_step_unit_test.sv -----
`timescale 1ns / 1ps

module fractional_pid_sample_step_unit_test;
    import fpss_pkg::*;
    import fpss_tb_pkg::*;

    localparam logic [31:0] Q_ONE     = 32'h1000_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hF000_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     fail_count;
    int                     pending;

    logic        steady = 1'b0;
    int          ready_hold = 0;
    logic [31:0] prev_err = '0;

    always #6 aclk = ~aclk;

    fractional_pid_sample_step_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    fractional_pid_sample_step_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        if (steady || !aresetn) begin
            m_tready <= aresetn;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(5) == 0) begin
            ready_hold <= $urandom_range(6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic mode, input logic [IN_TDATA_W-1:0] data);
        if (!steady && $urandom_range(5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tuser <= mode;
        s_tdata <= data;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_coef(input logic sel, input logic [3:0] sec, input logic [1:0] ci,
                             input logic [31:0] value);
        push_item(MODE_LOAD, {1'b0, 32'($urandom), value, ci, sec, sel});
    endtask

    task automatic sample(input logic [31:0] err);
        push_item(MODE_SAMPLE, {1'b0, err, 32'($urandom), 2'($urandom), 4'($urandom),
                                1'($urandom)});
        prev_err = err;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [31:0] regs [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= regs[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'($urandom);
            3: return '0;
            default: return 32'($signed(32'($urandom_range(0, 2 * 32'h1000_0000)))
                                - 32'sh1000_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        if ($urandom_range(7) == 0) return 32'($urandom);
        return 32'($signed(32'($urandom_range(0, 32'h1000_0000))) - 32'sh0800_0000);
    endfunction

    function automatic logic [31:0] pick_error();
        int unsigned r;
        logic signed [31:0] step;
        r = $urandom_range(9);
        if (r < 7) begin
            step = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
            return prev_err + step;
        end else if (r < 9) begin
            return 32'($signed(32'($urandom_range(0, 32'h2000_0000))) - 32'sh1000_0000);
        end
        return 32'($urandom);
    endfunction

    initial begin
        logic [31:0] regs [8];
        logic [3:0] sec_plan [8] = '{4'd2, 4'd1, 4'd11, 4'd0, 4'd3, 4'd15, 4'd2, 4'd4};
        int          count_plan [8] = '{280, 280, 70, 280, 280, 60, 280, 280};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int s = 0; s < 2; s++)
            for (int m = 0; m < TB_MAX_SECTIONS; m++)
                for (int c = 0; c < 4; c++)
                    load_coef(s[0], 4'(m), 2'(c), pick_coef());

        sample(Q_ONE);
        sample(Q_ONE + 32'd1);
        sample(Q_NEG_ONE);
        sample(Q_NEG_ONE - 32'd1);
        sample(Q_MAX);
        sample(Q_MIN);
        sample('0);
        sample(32'd161061274);
        sample(32'd322122548);
        sample(32'd161061273);
        load_coef(SEL_INTEG, 4'd11, COEF_B1, Q_MAX);
        load_coef(SEL_DIFF, 4'd15, COEF_A2, Q_MIN);
        load_coef(SEL_DIFF, 4'd10, COEF_A2, Q_MIN);
        load_coef(SEL_INTEG, 4'd0, COEF_B2, Q_MAX);
        sample(32'h0100_0000);
        sample(32'hFF00_0000);
        drain();

        regs = '{Q_MAX, Q_MAX, Q_MIN, 32'h7FFF_FFFF, 32'h0, 32'd11, Q_MIN, Q_MAX};
        write_regs(regs);
        sample(32'd1);
        sample(32'd1);
        sample(Q_NEG_ONE);
        sample(32'h0000_0010);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < 8; i++) regs[i] = pick_gain();
            regs[CFG_STEP_TIME] = (ph == 2) ? 32'h0 : (ph == 5) ? 32'h7FFF_FFFF
                                  : 32'($urandom_range(0, 32'h0100_0000));
            regs[CFG_JUMP_MARGIN] = (ph == 3) ? 32'h0 : (ph == 6) ? 32'h7FFF_FFFF
                                    : 32'($urandom_range(32'h0080_0000, 32'h1800_0000));
            regs[CFG_SECTIONS] = {28'd0, sec_plan[ph]};
            write_regs(regs);
            if (ph == 7) steady = 1'b1;
            for (int i = 0; i < count_plan[ph]; i++) begin
                if ($urandom_range(3) == 0) begin
                    load_coef(1'($urandom),
                              ($urandom_range(6) == 0) ? 4'($urandom_range(11, 15))
                                                        : 4'($urandom_range(0, 10)),
                              2'($urandom), pick_coef());
                end else begin
                    sample(pick_error());
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
